// File: sv/ipid_pkg.sv
// shared types and constants for the incremental pid block
`timescale 1ns / 1ps

package ipid_pkg;

   // fixed-point layout
   localparam int FRACTION_BITS = 8;
   localparam int DATA_W        = 16;
   localparam int ACC_W         = DATA_W + FRACTION_BITS;

   // error differences and product widths
   localparam int D1_W   = DATA_W + 1;
   localparam int D2_W   = DATA_W + 2;
   localparam int PP_W   = DATA_W + D1_W;
   localparam int IP_W   = DATA_W + DATA_W;
   localparam int DP_W   = DATA_W + D2_W;
   localparam int BASE_W = (ACC_W + 1 > DP_W) ? ACC_W + 1 : DP_W;
   localparam int SUM_W  = BASE_W + 2;

   // csr map
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_KP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_MAX = 3'd4;

   // command codes
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // clamp status codes
   localparam logic [1:0] CLAMP_NONE = 2'd0;
   localparam logic [1:0] CLAMP_HIGH = 2'd1;
   localparam logic [1:0] CLAMP_LOW  = 2'd2;

   // gains and limits
   typedef struct packed {
      logic signed [DATA_W-1:0] kp;
      logic signed [DATA_W-1:0] ki;
      logic signed [DATA_W-1:0] kd;
      logic        [DATA_W-1:0] out_min;
      logic        [DATA_W-1:0] out_max;
   } gains_type;

   // controller state
   typedef struct packed {
      logic        [ACC_W-1:0]  acc;
      logic signed [DATA_W-1:0] e1;
      logic signed [DATA_W-1:0] e2;
   } state_type;

endpackage

// File: sv/ipid_calc.sv
// one velocity-form pid update with clamp, pure combinational datapath
`timescale 1ns / 1ps

module ipid_calc (
   input  logic                             command,
   input  logic signed [ipid_pkg::DATA_W-1:0] error,
   input  ipid_pkg::gains_type              gains,
   input  ipid_pkg::state_type              state,
   output ipid_pkg::state_type              state_next,
   output logic        [ipid_pkg::DATA_W-1:0] drive,
   output logic        [1:0]                clamp_status
);
   import ipid_pkg::*;

   logic signed [D1_W-1:0]  d1;
   logic signed [D2_W-1:0]  d2;
   logic signed [PP_W-1:0]  p_prod;
   logic signed [IP_W-1:0]  i_prod;
   logic signed [DP_W-1:0]  d_prod;
   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] hi;
   logic signed [SUM_W-1:0] lo;
   logic        [ACC_W-1:0] acc_new;

   // error differences
   assign d1 = D1_W'(error) - D1_W'(state.e1);
   assign d2 = D2_W'(error) - (D2_W'(state.e1) <<< 1) + D2_W'(state.e2);

   // three gain products in parallel
   assign p_prod = PP_W'(gains.kp) * PP_W'(d1);
   assign i_prod = IP_W'(gains.ki) * IP_W'(error);
   assign d_prod = DP_W'(gains.kd) * DP_W'(d2);

   // accumulate
   assign sum = $signed({{(SUM_W-ACC_W){1'b0}}, state.acc})
              + SUM_W'(p_prod) + SUM_W'(i_prod) + SUM_W'(d_prod);

   // limits scaled to fixed point
   assign hi = $signed(SUM_W'(gains.out_max) << FRACTION_BITS);
   assign lo = $signed(SUM_W'(gains.out_min) << FRACTION_BITS);

   // clamp, high test wins, then select clear
   always_comb begin
      acc_new      = sum[ACC_W-1:0];
      clamp_status = CLAMP_NONE;
      if (sum > hi) begin
         acc_new      = ACC_W'(gains.out_max) << FRACTION_BITS;
         clamp_status = CLAMP_HIGH;
      end else if (sum < lo) begin
         acc_new      = ACC_W'(gains.out_min) << FRACTION_BITS;
         clamp_status = CLAMP_LOW;
      end
      state_next.acc = acc_new;
      state_next.e1  = error;
      state_next.e2  = state.e1;
      if (command == CMD_CLEAR) begin
         state_next   = '0;
         clamp_status = CLAMP_NONE;
      end
   end

   assign drive = state_next.acc[ACC_W-1:FRACTION_BITS];

endmodule

// File: sv/incremental_pid_clamped.sv
// top level: csr block, input register, pid update and result register
// a request passes through the input register and then the result register before rsp valid
// throughput: one item per cycle while rsp is not stalled; accumulator and error history update with the result
// the result register lets a new item enter while an earlier result waits
// reset (synchronous, active high) zeroes state and gains, sets out_max to all ones
`timescale 1ns / 1ps

module incremental_pid_clamped (
   input  logic                                clock,
   input  logic                                reset,
   // input item channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic signed [ipid_pkg::DATA_W-1:0]  req_error,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [ipid_pkg::DATA_W-1:0]  rsp_drive,
   output logic        [1:0]                   rsp_clamp_status,
   // csr port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ipid_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ipid_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ipid_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import ipid_pkg::*;

   gains_type                gains_ff;
   state_type                state_ff;
   state_type                state_in;
   logic                     in_valid_ff;
   logic                     in_command_ff;
   logic signed [DATA_W-1:0] in_error_ff;
   logic                     out_valid_ff;
   logic        [DATA_W-1:0] out_drive_ff;
   logic        [1:0]        out_status_ff;
   logic        [DATA_W-1:0] drive_in;
   logic        [1:0]        status_in;
   logic                     advance;
   logic                     csr_write;
   logic [CSR_IDX_W-1:0]     csr_idx;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp      <= '0;
         gains_ff.ki      <= '0;
         gains_ff.kd      <= '0;
         gains_ff.out_min <= '0;
         gains_ff.out_max <= '1;
      end else if (csr_write) begin
         case (csr_idx)
            REG_KP:      gains_ff.kp      <= csr_pwdata[DATA_W-1:0];
            REG_KI:      gains_ff.ki      <= csr_pwdata[DATA_W-1:0];
            REG_KD:      gains_ff.kd      <= csr_pwdata[DATA_W-1:0];
            REG_OUT_MIN: gains_ff.out_min <= csr_pwdata[DATA_W-1:0];
            REG_OUT_MAX: gains_ff.out_max <= csr_pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   // csr read back
   always_comb begin
      case (csr_idx)
         REG_KP:      csr_prdata = CSR_DATA_W'(unsigned'(gains_ff.kp));
         REG_KI:      csr_prdata = CSR_DATA_W'(unsigned'(gains_ff.ki));
         REG_KD:      csr_prdata = CSR_DATA_W'(unsigned'(gains_ff.kd));
         REG_OUT_MIN: csr_prdata = CSR_DATA_W'(gains_ff.out_min);
         REG_OUT_MAX: csr_prdata = CSR_DATA_W'(gains_ff.out_max);
         default:     csr_prdata = '0;
      endcase
   end

   // pipeline handshake
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         in_command_ff <= req_command;
         in_error_ff   <= req_error;
      end
   end

   // pid update
   ipid_calc u_calc (
      .command      (in_command_ff),
      .error        (in_error_ff),
      .gains        (gains_ff),
      .state        (state_ff),
      .state_next   (state_in),
      .drive        (drive_in),
      .clamp_status (status_in)
   );

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_drive_ff  <= drive_in;
         out_status_ff <= status_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_drive        = out_drive_ff;
   assign rsp_clamp_status = out_status_ff;

endmodule
